@@ sv/prq_pkg.sv @@
// shared constants, types and request codes for the priority request queue
package prq_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int REQ_W = 3;
  localparam int ID_W  = 8;
  localparam int PRI_W = 8;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // request codes as they arrive on the bus
  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MARK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

  // decoded operation
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_ERASE,
    OP_QUERY,
    OP_MARK,
    OP_CLEAR
  } op_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cmd_t;

  // result item, packed so status lands in the lowest bits of tdata
  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             out_valid;
    logic [PRI_W-1:0] out_priority;
    logic [ID_W-1:0]  out_task_id;
    status_t          status;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

@@ sv/priority_request_queue.sv @@
// top level of the priority request queue
// Bounded queue of up to 16 task requests kept in descending priority order,
// equal priorities in arrival order, with push, pop, erase by id, query,
// mark-head-in-progress and clear. Requests enter through a two-entry command
// queue and are carried out by a sorted register array that compares every
// slot in parallel, so one request completes per clock cycle when the result
// side keeps taking transfers. An accepted request is written into the command queue,
// then executed against the array with its result registered for the output; a result
// not yet taken holds execution back. Each request gives exactly one result; a new
// request is taken while a result still waits.
module priority_request_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // task_id[7:0], task_priority[15:8]
  input  logic [prq_pkg::REQ_W-1:0]  in_tuser,   // req_type[2:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [prq_pkg::RES_W-1:0]  out_tdata   // status[1:0], out_task_id[9:2],
                                                  // out_priority[17:10], out_valid[18],
                                                  // entry_count[23:19]
);
  import prq_pkg::*;

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t result;

  // request classification and buffering
  prq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // execution against the entry array
  prq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  assign out_tdata = result;

endmodule

@@ sv/prq_front.sv @@
// request decode and short command queue feeding the execution back end
module prq_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // task_id[7:0], task_priority[15:8]
  input  logic [prq_pkg::REQ_W-1:0]   in_tuser,   // req_type[2:0]
  output logic                        cmd_valid,
  input  logic                        cmd_pop,
  output prq_pkg::cmd_t               cmd
);
  import prq_pkg::*;

  cmd_t              mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              dec_cmd;
  logic              push;

  // classify the incoming request
  always_comb begin
    dec_cmd.id  = in_tdata[ID_W-1:0];
    dec_cmd.pri = in_tdata[ID_W+PRI_W-1:ID_W];
    case (in_tuser)
      REQ_PUSH:  dec_cmd.op = OP_PUSH;
      REQ_POP:   dec_cmd.op = OP_POP;
      REQ_ERASE: dec_cmd.op = OP_ERASE;
      REQ_QUERY: dec_cmd.op = OP_QUERY;
      REQ_MARK:  dec_cmd.op = OP_MARK;
      REQ_CLEAR: dec_cmd.op = OP_CLEAR;
      default:   dec_cmd.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != FCNT_W'(FIFO_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, cmd_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

@@ sv/prq_back.sv @@
// sorted shift-register entry array executing one command per cycle while results are taken
module prq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  prq_pkg::cmd_t     cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output prq_pkg::result_t  result
);
  import prq_pkg::*;

  logic [ID_W-1:0]  task_r [QUEUE_DEPTH];
  logic [PRI_W-1:0] pri_r  [QUEUE_DEPTH];
  logic [ID_W-1:0]  task_nxt [QUEUE_DEPTH];
  logic [PRI_W-1:0] pri_nxt  [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r;
  result_t          result_r, result_nxt;

  logic [QUEUE_DEPTH-1:0] occ, behind, ahead, match, upto, first;
  logic                   found;
  logic [ID_W-1:0]        follow_id;
  logic                   follow_v;
  logic                   exec;

  assign exec       = cmd_valid && (!out_valid_r || out_tready);
  assign cmd_pop    = exec;
  assign out_tvalid = out_valid_r;
  assign result     = result_r;

  // per-slot compares against the command
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      occ[k]    = (CNT_W'(k) < count_r);
      behind[k] = (occ[k] && (pri_r[k] >= cmd.pri)) || ((k == 0) && busy_r && occ[0]);
      match[k]  = occ[k] && (task_r[k] == cmd.id);
    end
    ahead[0] = behind[0];
    upto[0]  = match[0];
    first[0] = match[0];
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      ahead[k] = ahead[k-1] && behind[k];
      upto[k]  = upto[k-1] || match[k];
      first[k] = match[k] && !upto[k-1];
    end
    found = upto[QUEUE_DEPTH-1];
  end

  // entry that follows the first match
  always_comb begin
    follow_id = '0;
    follow_v  = 1'b0;
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      if (first[k] && occ[k+1]) begin
        follow_id = follow_id | task_r[k+1];
        follow_v  = 1'b1;
      end
    end
  end

  // operation execution
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      task_nxt[k] = task_r[k];
      pri_nxt[k]  = pri_r[k];
    end
    count_nxt               = count_r;
    busy_nxt                = busy_r;
    result_nxt.status       = ST_OK;
    result_nxt.out_task_id  = '0;
    result_nxt.out_priority = '0;
    result_nxt.out_valid    = 1'b0;
    case (cmd.op)
      OP_PUSH: begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          result_nxt.status = ST_FULL;
        end else begin
          if (!ahead[0]) begin
            task_nxt[0] = cmd.id;
            pri_nxt[0]  = cmd.pri;
          end
          for (int k = 1; k < QUEUE_DEPTH; k++) begin
            if (!ahead[k]) begin
              task_nxt[k] = ahead[k-1] ? cmd.id  : task_r[k-1];
              pri_nxt[k]  = ahead[k-1] ? cmd.pri : pri_r[k-1];
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          result_nxt.status = ST_MISS;
        end else begin
          result_nxt.out_task_id  = task_r[0];
          result_nxt.out_priority = pri_r[0];
          result_nxt.out_valid    = 1'b1;
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            task_nxt[k] = task_r[k+1];
            pri_nxt[k]  = pri_r[k+1];
          end
          count_nxt = count_r - 1'b1;
          busy_nxt  = 1'b0;
        end
      end
      OP_ERASE: begin
        if (!found) begin
          result_nxt.status = ST_MISS;
        end else begin
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (upto[k]) begin
              task_nxt[k] = task_r[k+1];
              pri_nxt[k]  = pri_r[k+1];
            end
          end
          count_nxt = count_r - 1'b1;
          if (match[0]) begin
            busy_nxt = 1'b0;
          end
          result_nxt.out_task_id = follow_id;
          result_nxt.out_valid   = follow_v;
        end
      end
      OP_QUERY: begin
        if (found) begin
          result_nxt.out_valid = 1'b1;
        end else begin
          result_nxt.status = ST_MISS;
        end
      end
      OP_MARK: begin
        if (count_r == '0) begin
          result_nxt.status = ST_MISS;
        end else begin
          busy_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        busy_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
    result_nxt.entry_count = count_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        count_r <= count_nxt;
        busy_r  <= busy_nxt;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entry array and result register
  always_ff @(posedge clk) begin
    if (exec) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        task_r[k] <= task_nxt[k];
        pri_r[k]  <= pri_nxt[k];
      end
      result_r <= result_nxt;
    end
  end

endmodule

@@ bench/priority_request_queue_tb.sv @@
// self-checking testbench for the priority request queue: directed and random stream traffic
module priority_request_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prq_pkg::*;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1100;
  localparam int MAX_REPORTS     = 10;

  // random phase flavors
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_MARK} phase_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } request_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;   // task_id[7:0], task_priority[15:8]
  logic [REQ_W-1:0] in_tuser = '0;   // req_type[2:0]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [RES_W-1:0] out_tdata;       // status, out_task_id, out_priority, out_valid, entry_count

  priority_request_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // requests waiting to be sent and results still owed by the block
  request_t pending_requests[$];
  result_t  owed_results[$];

  // shadow copy of the queue contents
  logic [ID_W-1:0]  shadow_id  [QUEUE_DEPTH];
  logic [PRI_W-1:0] shadow_pri [QUEUE_DEPTH];
  int               shadow_cnt = 0;
  bit               shadow_busy = 1'b0;

  int mismatches = 0;
  int unexpected = 0;
  int op_seen [8];
  int full_refusals = 0;
  int held_behind_head = 0;
  int erase_with_follower = 0;
  int peak_cnt = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // gap lengths: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int k = 0; k < shadow_cnt; k++)
      if (shadow_id[k] == id) return k;
    return -1;
  endfunction

  function automatic void remove_slot(int pos);
    for (int k = pos; k + 1 < shadow_cnt; k++) begin
      shadow_id[k]  = shadow_id[k + 1];
      shadow_pri[k] = shadow_pri[k + 1];
    end
    shadow_cnt--;
    if (pos == 0) shadow_busy = 1'b0;
  endfunction

  // applies one request to the shadow queue and returns the result it owes
  function automatic result_t apply_request(request_t r);
    result_t res;
    int      p;
    int      pos;
    res = '0;
    res.status = ST_OK;
    op_seen[r.req]++;
    case (r.req)
      REQ_PUSH: begin
        if (shadow_cnt >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          // a marked head keeps its place
          p = (shadow_cnt > 0 && shadow_busy) ? 1 : 0;
          if (p == 1 && r.pri > shadow_pri[0]) held_behind_head++;
          while (p < shadow_cnt && shadow_pri[p] >= r.pri) p++;
          for (int k = shadow_cnt; k > p; k--) begin
            shadow_id[k]  = shadow_id[k - 1];
            shadow_pri[k] = shadow_pri[k - 1];
          end
          shadow_id[p]  = r.id;
          shadow_pri[p] = r.pri;
          shadow_cnt++;
          if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
        end
      end
      REQ_POP: begin
        if (shadow_cnt == 0) begin
          res.status = ST_MISS;
        end else begin
          res.out_task_id  = shadow_id[0];
          res.out_priority = shadow_pri[0];
          res.out_valid    = 1'b1;
          remove_slot(0);
        end
      end
      REQ_ERASE: begin
        pos = find_slot(r.id);
        if (pos < 0) begin
          res.status = ST_MISS;
        end else begin
          remove_slot(pos);
          // report the entry that moved into the freed slot
          if (pos < shadow_cnt) begin
            res.out_task_id = shadow_id[pos];
            res.out_valid   = 1'b1;
            erase_with_follower++;
          end
        end
      end
      REQ_QUERY: begin
        if (find_slot(r.id) >= 0) res.out_valid = 1'b1;
        else res.status = ST_MISS;
      end
      REQ_MARK: begin
        if (shadow_cnt == 0) res.status = ST_MISS;
        else shadow_busy = 1'b1;
      end
      REQ_CLEAR: begin
        shadow_cnt  = 0;
        shadow_busy = 1'b0;
      end
      default: ;
    endcase
    res.entry_count = shadow_cnt[CNT_W-1:0];
    return res;
  endfunction

  // driver: presents the next pending request, with random gaps
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        nxt = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.pri, nxt.id};
        in_tuser  <= nxt.req;
        // stretches without gaps now and then
        if (send_calm > 0) begin
          send_calm <= send_calm - 1;
        end else begin
          if ($urandom_range(0, 9) == 0) send_calm <= $urandom_range(20, 80);
          send_gap <= pick_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_stall <= pick_gap();
        if ($urandom_range(0, 9) == 0) recv_calm <= $urandom_range(20, 80);
      end
    end
  end

  // monitor: checks each result transfer, then records the owed result of a new request
  always @(posedge clk) begin : watch_transfers
    result_t got;
    result_t want;
    request_t taken;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (owed_results.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display("%0t: result transfer with nothing owed: %h", $realtime, out_tdata);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.out_task_id !== want.out_task_id ||
              got.out_priority !== want.out_priority || got.out_valid !== want.out_valid ||
              got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches + unexpected <= MAX_REPORTS) begin
              $display("%0t: expected st=%0d id=%0d pri=%0d vld=%0d cnt=%0d",
                       $realtime, want.status, want.out_task_id, want.out_priority,
                       want.out_valid, want.entry_count);
              $display("%0t:      got st=%0d id=%0d pri=%0d vld=%0d cnt=%0d",
                       $realtime, got.status, got.out_task_id, got.out_priority,
                       got.out_valid, got.entry_count);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken.req = in_tuser;
        taken.id  = in_tdata[7:0];
        taken.pri = in_tdata[15:8];
        owed_results.push_back(apply_request(taken));
      end
    end
  end

  task automatic add_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                             logic [PRI_W-1:0] pri);
    request_t r;
    r.req = req;
    r.id  = id;
    r.pri = pri;
    pending_requests.push_back(r);
  endtask

  // hold until everything sent has been answered, checked away from the active edge
  task automatic drain();
    while (pending_requests.size() > 0 || in_tvalid || owed_results.size() > 0)
      @(negedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 70) return REQ_PUSH;
        if (r < 80) return REQ_QUERY;
        if (r < 90) return REQ_ERASE;
        if (r < 96) return REQ_POP;
        return REQ_MARK;
      end
      PH_DRAIN: begin
        if (r < 25) return REQ_PUSH;
        if (r < 60) return REQ_POP;
        if (r < 75) return REQ_ERASE;
        if (r < 90) return REQ_QUERY;
        return REQ_MARK;
      end
      PH_MARK: begin
        if (r < 45) return REQ_PUSH;
        if (r < 65) return REQ_MARK;
        if (r < 80) return REQ_POP;
        if (r < 90) return REQ_ERASE;
        return REQ_QUERY;
      end
      default: begin
        if (r < 1) return REQ_RSVD6;
        if (r < 2) return REQ_RSVD7;
        if (r < 4) return REQ_CLEAR;
        if (r < 40) return REQ_PUSH;
        if (r < 60) return REQ_POP;
        if (r < 75) return REQ_ERASE;
        if (r < 88) return REQ_QUERY;
        return REQ_MARK;
      end
    endcase
  endfunction

  initial begin : stimulus
    int           made;
    int           phase_len;
    int           phase_no;
    phase_t       ph;
    logic [2:0]   op;
    logic [7:0]   id;
    logic [7:0]   pri;
    made = 0;
    phase_no = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-queue misses and reserved codes
    add_request(REQ_POP,   8'd0,   8'd0);
    add_request(REQ_MARK,  8'd0,   8'd0);
    add_request(REQ_ERASE, 8'd5,   8'd0);
    add_request(REQ_QUERY, 8'd5,   8'd0);
    add_request(REQ_RSVD6, 8'd0,   8'd0);
    add_request(REQ_RSVD7, 8'd255, 8'd255);
    // ordering extremes, equal priorities and a duplicate id
    add_request(REQ_PUSH,  8'd0,   8'd0);
    add_request(REQ_PUSH,  8'd255, 8'd255);
    add_request(REQ_PUSH,  8'd7,   8'd0);
    add_request(REQ_PUSH,  8'd7,   8'd128);
    add_request(REQ_QUERY, 8'd7,   8'd0);
    add_request(REQ_POP,   8'd0,   8'd0);
    // marked head stays ahead of a higher priority push
    add_request(REQ_MARK,  8'd0,   8'd0);
    add_request(REQ_MARK,  8'd0,   8'd0);
    add_request(REQ_PUSH,  8'd9,   8'd200);
    add_request(REQ_QUERY, 8'd9,   8'd0);
    // erase of a marked head, then of the last entry
    add_request(REQ_ERASE, 8'd7,   8'd0);
    add_request(REQ_ERASE, 8'd7,   8'd0);
    add_request(REQ_PUSH,  8'd200, 8'd1);
    add_request(REQ_POP,   8'd0,   8'd0);
    add_request(REQ_CLEAR, 8'd0,   8'd0);
    add_request(REQ_POP,   8'd0,   8'd0);
    drain();

    // random phases; every fourth one waits for the block to go quiet
    while (made < RANDOM_REQUESTS) begin
      ph = phase_t'($urandom_range(0, 3));
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len && made < RANDOM_REQUESTS; n++) begin
        op  = pick_op(ph);
        // small id pool so that erase and query often hit
        id  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        // narrow priorities give many ties
        pri = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        add_request(op, id, pri);
        if (op != REQ_RSVD6 && op != REQ_RSVD7) made++;
      end
      phase_no++;
      if (phase_no % 4 == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);

    $display("covered push %0d (%0d refused full, %0d held behind a marked head)",
             op_seen[REQ_PUSH], full_refusals, held_behind_head);
    $display("pop %0d, erase %0d (%0d with follower), query %0d, mark %0d, clear %0d",
             op_seen[REQ_POP], op_seen[REQ_ERASE], erase_with_follower,
             op_seen[REQ_QUERY], op_seen[REQ_MARK], op_seen[REQ_CLEAR]);
    $display("reserved %0d, peak occupancy %0d, failures %0d",
             op_seen[REQ_RSVD6] + op_seen[REQ_RSVD7], peak_cnt,
             mismatches + unexpected + owed_results.size());
    if (mismatches == 0 && unexpected == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/prq_pkg.sv
sv/prq_front.sv
sv/prq_back.sv
sv/priority_request_queue.sv
bench/priority_request_queue_tb.sv
